@@ hdl/ggc_pkg.sv @@
package ggc_pkg;

   localparam int MaxVerticesDefault = 16;
   localparam int DegreeWidthDefault = 8;
   localparam int IdWidth = 8;
   localparam int ColourWidth = 5;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_RUN   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIND,
      ST_ADD,
      ST_SORT_LOAD,
      ST_SORT_CMP,
      ST_CLR_COL,
      ST_COL_LOAD,
      ST_COL_SCAN,
      ST_COL_STORE,
      ST_EMIT,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic find_start;
      logic add_commit;
      logic sort_load;
      logic sort_shift;
      logic sort_place;
      logic col_clear;
      logic col_load;
      logic col_step;
      logic col_store;
      logic emit_load;
      logic graph_clear;
      logic idx_inc;
      logic idx_zero;
   } cmd_type;

   typedef struct packed {
      logic find_done;
      logic sort_outer_done;
      logic sort_should_shift;
      logic sort_h_zero;
      logic idx_done;
      logic col_done;
      logic empty;
   } sts_type;

endpackage

@@ hdl/ggc_if.sv @@
interface ggc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] first_vertex;
   logic [7:0] second_vertex;
   modport source (output valid, op, first_vertex, second_vertex, input ready);
   modport sink (input valid, op, first_vertex, second_vertex, output ready);
endinterface

interface ggc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] vertex_id;
   logic [4:0] vertex_colour;
   logic [4:0] colours_used;
   logic       overflow;
   logic       last;
   modport source (output valid, vertex_id, vertex_colour, colours_used, overflow, last,
                   input ready);
   modport sink (input valid, vertex_id, vertex_colour, colours_used, overflow, last,
                 output ready);
endinterface

@@ hdl/ggc_ctrl.sv @@
module ggc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [1:0]       req_op,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ggc_pkg::cmd_type cmd,
   input  ggc_pkg::sts_type sts
);
   import ggc_pkg::*;

   state_type state_ff, state_in;
   op_type    op;

   assign op = op_type'(req_op);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (op)
                  OP_ADD:   state_in = ST_FIND;
                  OP_RUN:   state_in = sts.empty ? ST_IDLE : ST_SORT_LOAD;
                  OP_CLEAR: state_in = ST_CLEAR;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_FIND:      if (sts.find_done) state_in = ST_ADD;
         ST_ADD:       state_in = ST_IDLE;
         ST_SORT_LOAD: state_in = sts.sort_outer_done ? ST_CLR_COL : ST_SORT_CMP;
         ST_SORT_CMP: begin
            if (sts.sort_h_zero || !sts.sort_should_shift) state_in = ST_SORT_LOAD;
         end
         ST_CLR_COL:   state_in = ST_COL_LOAD;
         ST_COL_LOAD:  state_in = ST_COL_SCAN;
         ST_COL_SCAN:  if (sts.col_done) state_in = ST_COL_STORE;
         ST_COL_STORE: state_in = sts.idx_done ? ST_EMIT : ST_COL_LOAD;
         ST_EMIT:      if (rsp_ready && sts.idx_done) state_in = ST_IDLE;
         ST_CLEAR:     state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && op == OP_ADD) cmd.find_start = 1'b1;
         end
         ST_FIND:      cmd.idx_inc = 1'b1;
         ST_ADD:       cmd.add_commit = 1'b1;
         ST_SORT_LOAD: cmd.sort_load = 1'b1;
         ST_SORT_CMP: begin
            if (!sts.sort_h_zero && sts.sort_should_shift) cmd.sort_shift = 1'b1;
            else cmd.sort_place = 1'b1;
         end
         ST_CLR_COL: begin
            cmd.col_clear = 1'b1;
            cmd.idx_zero  = 1'b1;
         end
         ST_COL_LOAD:  cmd.col_load = 1'b1;
         ST_COL_SCAN:  cmd.col_step = 1'b1;
         ST_COL_STORE: begin
            cmd.col_store = 1'b1;
            if (sts.idx_done) cmd.idx_zero = 1'b1;
            else cmd.idx_inc = 1'b1;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) cmd.idx_inc = 1'b1;
         end
         ST_CLEAR:     cmd.graph_clear = 1'b1;
         default: ;
      endcase
      cmd.emit_load = 1'b0;
   end

endmodule

@@ hdl/ggc_dp.sv @@
module ggc_dp #(
   parameter int MaxVertices = ggc_pkg::MaxVerticesDefault,
   parameter int DegreeWidth = ggc_pkg::DegreeWidthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       req_first_vertex,
   input  logic [7:0]       req_second_vertex,
   input  logic             req_take,
   output logic [7:0]       rsp_vertex_id,
   output logic [4:0]       rsp_vertex_colour,
   output logic [4:0]       rsp_colours_used,
   output logic             rsp_overflow,
   output logic             rsp_last,
   input  ggc_pkg::cmd_type cmd,
   output ggc_pkg::sts_type sts
);
   import ggc_pkg::*;

   localparam int SW = $clog2(MaxVertices);
   localparam int CW = $clog2(MaxVertices + 1);
   localparam logic [DegreeWidth-1:0] DegMax = '1;

   logic [7:0]             ids_ff [MaxVertices];
   logic [DegreeWidth-1:0] deg_ff [MaxVertices];
   logic [MaxVertices-1:0] adj_ff [MaxVertices];
   logic [ColourWidth-1:0] col_ff [MaxVertices];
   logic [SW-1:0]          ord_ff [MaxVertices];
   logic [CW-1:0]          count_ff;
   logic                   drop_ff;

   logic [7:0]    a_ff, b_ff;
   logic [CW-1:0] idx_ff, idx_in;
   logic          fa_ff, fb_ff;
   logic [SW-1:0] sa_ff, sb_ff;

   logic [CW-1:0]          i_ff;
   logic [CW-1:0]          h_ff;
   logic [SW-1:0]          item_ff;
   logic [DegreeWidth-1:0] item_deg_ff;

   logic [SW-1:0]          cur_ff;
   logic [MaxVertices-1:0] row_ff;
   logic [ColourWidth-1:0] cand_ff;
   logic [CW-1:0]          k_ff;
   logic                   taken_ff;
   logic [ColourWidth-1:0] used_ff;

   logic [SW-1:0] idx_s, k_s, h_s, hm1_s, i_s;
   logic          hit;

   assign idx_s = idx_ff[SW-1:0];
   assign k_s   = k_ff[SW-1:0];
   assign h_s   = h_ff[SW-1:0];
   assign hm1_s = SW'(h_ff - CW'(1));
   assign i_s   = i_ff[SW-1:0];
   assign hit   = (k_ff < count_ff) && row_ff[k_s] && col_ff[k_s] == cand_ff;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.find_start || cmd.idx_zero) idx_in = '0;
      else if (cmd.idx_inc) idx_in = idx_ff + CW'(1);
   end

   assign sts.find_done         = (idx_ff + CW'(1) >= count_ff) || (count_ff == '0);
   assign sts.sort_outer_done   = (i_ff >= count_ff);
   assign sts.sort_should_shift = deg_ff[ord_ff[hm1_s]] > item_deg_ff;
   assign sts.sort_h_zero       = (h_ff == '0);
   assign sts.idx_done          = (idx_ff + CW'(1) == count_ff);
   assign sts.col_done          = (k_ff + CW'(1) >= count_ff) && !hit;
   assign sts.empty             = (count_ff == '0);

   always_ff @(posedge clock) begin
      logic [SW-1:0] na, nb;
      logic [CW-1:0] need;
      logic          sa_new, sb_new;
      if (reset || cmd.graph_clear) begin
         count_ff <= '0;
         drop_ff  <= 1'b0;
         used_ff  <= '0;
         for (int v = 0; v < MaxVertices; v++) begin
            adj_ff[v] <= '0;
            col_ff[v] <= '0;
         end
      end else begin
         idx_ff <= idx_in;
         if (cmd.find_start) begin
            a_ff  <= req_first_vertex;
            b_ff  <= req_second_vertex;
            fa_ff <= 1'b0;
            fb_ff <= 1'b0;
         end
         if (cmd.idx_inc && !cmd.col_store && !cmd.emit_load && idx_ff < count_ff
             && !cmd.add_commit) begin
            if (ids_ff[idx_s] == a_ff && !fa_ff) begin
               fa_ff <= 1'b1;
               sa_ff <= idx_s;
            end
            if (ids_ff[idx_s] == b_ff && !fb_ff) begin
               fb_ff <= 1'b1;
               sb_ff <= idx_s;
            end
         end
         if (cmd.add_commit) begin
            sa_new = !fa_ff;
            sb_new = !fb_ff && (a_ff != b_ff);
            need   = CW'(sa_new) + CW'(sb_new);
            na = fa_ff ? sa_ff : count_ff[SW-1:0];
            nb = fb_ff ? sb_ff : (a_ff == b_ff ? na : SW'(count_ff + CW'(sa_new)));
            if ((CW+1)'(count_ff) + (CW+1)'(need) > (CW+1)'(MaxVertices)) begin
               drop_ff <= 1'b1;
            end else begin
               if (sa_new) begin
                  ids_ff[na] <= a_ff;
                  ord_ff[na] <= na;
                  col_ff[na] <= '0;
               end
               if (sb_new) begin
                  ids_ff[nb] <= b_ff;
                  ord_ff[nb] <= nb;
                  col_ff[nb] <= '0;
               end
               count_ff <= count_ff + need;
               for (int v = 0; v < MaxVertices; v++) begin
                  if (SW'(v) == na || SW'(v) == nb) begin
                     logic [MaxVertices-1:0] base;
                     logic [DegreeWidth-1:0] d;
                     logic [DegreeWidth-1:0] d1;
                     base = ((SW'(v) == na && sa_new) || (SW'(v) == nb && sb_new))
                            ? '0 : adj_ff[v];
                     d    = ((SW'(v) == na && sa_new) || (SW'(v) == nb && sb_new))
                            ? '0 : deg_ff[v];
                     if (SW'(v) == na) base[nb] = 1'b1;
                     if (SW'(v) == nb) base[na] = 1'b1;
                     d1 = (d < DegMax) ? d + DegreeWidth'(1) : d;
                     if (na == nb) d1 = (d1 < DegMax) ? d1 + DegreeWidth'(1) : d1;
                     adj_ff[v] <= base;
                     deg_ff[v] <= d1;
                  end
               end
            end
         end
         if (req_take) i_ff <= CW'(1);
         if (cmd.sort_load && i_ff < count_ff) begin
            item_ff     <= ord_ff[i_s];
            item_deg_ff <= deg_ff[ord_ff[i_s]];
            h_ff        <= i_ff;
         end
         if (cmd.sort_shift) begin
            ord_ff[h_s] <= ord_ff[hm1_s];
            h_ff        <= h_ff - CW'(1);
         end
         if (cmd.sort_place) begin
            ord_ff[h_s] <= item_ff;
            i_ff        <= i_ff + CW'(1);
         end
         if (cmd.col_clear) begin
            used_ff <= '0;
            for (int v = 0; v < MaxVertices; v++) col_ff[v] <= '0;
         end
         if (cmd.col_load) begin
            cur_ff  <= ord_ff[idx_s];
            row_ff  <= adj_ff[ord_ff[idx_s]];
            cand_ff <= ColourWidth'(1);
            k_ff    <= '0;
         end
         if (cmd.col_step) begin
            if (hit) begin
               cand_ff <= cand_ff + ColourWidth'(1);
               k_ff    <= '0;
            end else begin
               k_ff <= k_ff + CW'(1);
            end
         end
         if (cmd.col_store) begin
            col_ff[cur_ff] <= cand_ff;
            if (cand_ff > used_ff) used_ff <= cand_ff;
         end
      end
   end

   assign rsp_vertex_id     = ids_ff[ord_ff[idx_s]];
   assign rsp_vertex_colour = col_ff[ord_ff[idx_s]];
   assign rsp_colours_used  = used_ff;
   assign rsp_overflow      = drop_ff;
   assign rsp_last          = sts.idx_done;

endmodule

@@ hdl/greedy_graph_colouring_core.sv @@
// Channel  Dir  Fields
// req      in   op, first_vertex, second_vertex
// rsp      out  vertex_id, vertex_colour, colours_used, overflow, last
//
// Edge word: a linear id search over the vertex table, then the table update.
// Run word: insertion sort, then colouring scans over the vertex table for
// each tried colour of each vertex, then one result word per cycle while rsp is ready.
// Reset is synchronous and empties the graph. A stalled rsp holds the word;
// req is taken only while idle.
module greedy_graph_colouring_core #(
   parameter int MaxVertices = ggc_pkg::MaxVerticesDefault,
   parameter int DegreeWidth = ggc_pkg::DegreeWidthDefault
) (
   input logic clock,
   input logic reset,
   ggc_req_if.sink   req,
   ggc_rsp_if.source rsp
);
   import ggc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ggc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_op    (req.op),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   ggc_dp #(
      .MaxVertices (MaxVertices),
      .DegreeWidth (DegreeWidth)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_first_vertex  (req.first_vertex),
      .req_second_vertex (req.second_vertex),
      .req_take          (req.valid && req.ready),
      .rsp_vertex_id     (rsp.vertex_id),
      .rsp_vertex_colour (rsp.vertex_colour),
      .rsp_colours_used  (rsp.colours_used),
      .rsp_overflow      (rsp.overflow),
      .rsp_last          (rsp.last),
      .cmd               (cmd),
      .sts               (sts)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("req taken during emit");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.vertex_id))
      else $error("rsp word changed under stall");
   a_colour: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.vertex_colour != '0 && rsp.vertex_colour <= rsp.colours_used)
      else $error("colour out of range");

endmodule

@@ sim/tb_greedy_graph_colouring_core.sv @@
`timescale 1ns / 1ps
module tb_greedy_graph_colouring_core;
   import ggc_pkg::*;

   localparam int NumVertices = MaxVerticesDefault;
   localparam int DegreeMax = (1 << DegreeWidthDefault) - 1;
   localparam int IdleLimit = 200000;

   typedef struct packed {
      op_type     op;
      logic [7:0] first_vertex;
      logic [7:0] second_vertex;
   } edge_word_type;

   typedef struct packed {
      logic [7:0] vertex_id;
      logic [4:0] vertex_colour;
      logic [4:0] colours_used;
      logic       overflow;
      logic       last;
   } colour_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ggc_req_if req ();
   ggc_rsp_if rsp ();

   greedy_graph_colouring_core u_dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   edge_word_type   pending_words[$];
   colour_word_type expected_colours[$];
   bit              failed = 1'b0;
   bit              stimulus_done = 1'b0;
   int              idle_cycles = 0;

   logic [7:0]            graph_ids[NumVertices];
   int                    graph_count;
   int                    graph_degree[NumVertices];
   logic [NumVertices-1:0] graph_adj[NumVertices];
   int                    graph_colour[NumVertices];
   int                    graph_order[NumVertices];
   bit                    graph_dropped;

   function automatic void clear_graph();
      graph_count = 0;
      graph_dropped = 1'b0;
      for (int i = 0; i < NumVertices; i++) begin
         graph_adj[i] = '0;
         graph_colour[i] = 0;
         graph_degree[i] = 0;
         graph_order[i] = i;
         graph_ids[i] = '0;
      end
   endfunction

   function automatic int lookup_slot(logic [7:0] id);
      for (int i = 0; i < graph_count; i++)
         if (graph_ids[i] == id) return i;
      return -1;
   endfunction

   function automatic int claim_slot(logic [7:0] id);
      int s;
      s = graph_count;
      graph_ids[s] = id;
      graph_degree[s] = 0;
      graph_adj[s] = '0;
      graph_colour[s] = 0;
      graph_order[s] = s;
      graph_count++;
      return s;
   endfunction

   function automatic void insert_edge(logic [7:0] a, logic [7:0] b);
      int fa, fb, need, sa, sb;
      fa = lookup_slot(a);
      fb = lookup_slot(b);
      if (a == b) need = (fa < 0);
      else need = (fa < 0) + (fb < 0);
      if (graph_count + need > NumVertices) begin
         graph_dropped = 1'b1;
         return;
      end
      sa = (fa < 0) ? claim_slot(a) : fa;
      fb = lookup_slot(b);
      sb = (fb < 0) ? claim_slot(b) : fb;
      graph_adj[sa][sb] = 1'b1;
      graph_adj[sb][sa] = 1'b1;
      if (graph_degree[sa] < DegreeMax) graph_degree[sa]++;
      if (graph_degree[sb] < DegreeMax) graph_degree[sb]++;
   endfunction

   function automatic void colour_graph();
      int n, item, h, s, c, used;
      bit taken;
      colour_word_type w;
      n = graph_count;
      used = 0;
      for (int i = 1; i < n; i++) begin
         item = graph_order[i];
         h = i;
         while (h > 0 && graph_degree[graph_order[h-1]] > graph_degree[item]) begin
            graph_order[h] = graph_order[h-1];
            h--;
         end
         graph_order[h] = item;
      end
      for (int i = 0; i < n; i++) graph_colour[i] = 0;
      for (int i = 0; i < n; i++) begin
         s = graph_order[i];
         for (c = 1; c <= n; c++) begin
            taken = 1'b0;
            for (int k = 0; k < n; k++)
               if (graph_adj[s][k] && graph_colour[k] == c) taken = 1'b1;
            if (!taken) break;
         end
         graph_colour[s] = c;
         if (c > used) used = c;
      end
      for (int i = 0; i < n; i++) begin
         s = graph_order[i];
         w.vertex_id = graph_ids[s];
         w.vertex_colour = 5'(graph_colour[s]);
         w.colours_used = 5'(used);
         w.overflow = graph_dropped;
         w.last = (i + 1 == n);
         expected_colours.push_back(w);
      end
   endfunction

   function automatic void predict(edge_word_type w);
      case (w.op)
         OP_ADD: insert_edge(w.first_vertex, w.second_vertex);
         OP_RUN: colour_graph();
         OP_CLEAR: clear_graph();
         default: ;
      endcase
   endfunction

   function automatic int gap_length();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   function automatic void push_word(op_type op, int a, int b);
      edge_word_type w;
      w.op = op;
      w.first_vertex = 8'(a);
      w.second_vertex = 8'(b);
      pending_words.push_back(w);
   endfunction

   // driver
   int send_gap = 0;
   int quiet_phase = 0;
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (req.valid && !req.ready) begin
      end else begin
         if (req.valid) begin
            predict(pending_words.pop_front());
         end
         if (quiet_phase > 0) quiet_phase--;
         else if ($urandom_range(0, 199) == 0) quiet_phase = 100;
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req.valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            req.valid <= 1'b1;
            {req.op, req.first_vertex, req.second_vertex} <= pending_words[0];
            send_gap <= quiet_phase > 0 ? 0 : gap_length();
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // monitor
   int stall = 0;
   colour_word_type got, exp_w;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = {rsp.vertex_id, rsp.vertex_colour, rsp.colours_used, rsp.overflow, rsp.last};
            if (expected_colours.size() == 0) begin
               $display("%0t: unexpected word %h", $time, got);
               failed = 1'b1;
            end else begin
               exp_w = expected_colours.pop_front();
               if (got.vertex_id !== exp_w.vertex_id)
                  $display("%0t: vertex_id exp %0d got %0d", $time, exp_w.vertex_id, got.vertex_id);
               if (got.vertex_colour !== exp_w.vertex_colour)
                  $display("%0t: vertex_colour exp %0d got %0d", $time,
                           exp_w.vertex_colour, got.vertex_colour);
               if (got.colours_used !== exp_w.colours_used)
                  $display("%0t: colours_used exp %0d got %0d", $time,
                           exp_w.colours_used, got.colours_used);
               if (got.overflow !== exp_w.overflow)
                  $display("%0t: overflow exp %0d got %0d", $time, exp_w.overflow, got.overflow);
               if (got.last !== exp_w.last)
                  $display("%0t: last exp %0d got %0d", $time, exp_w.last, got.last);
               if (got !== exp_w) failed = 1'b1;
            end
         end
         if (stall > 0) begin
            stall <= stall - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
            if ($urandom_range(0, 2) == 0) stall <= gap_length();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("greedy_graph_colouring_core regression: fail");
         $finish;
      end
   end

   int pool_size;
   initial begin
      req.valid = 1'b0;
      req.op = OP_NONE;
      req.first_vertex = '0;
      req.second_vertex = '0;
      rsp.ready = 1'b0;
      clear_graph();

      push_word(OP_RUN, 0, 0);
      push_word(OP_ADD, 0, 255);
      push_word(OP_ADD, 255, 255);
      push_word(OP_ADD, 8'hAA, 8'h55);
      push_word(OP_ADD, 0, 8'h55);
      push_word(OP_ADD, 0, 255);
      push_word(OP_NONE, 1, 2);
      push_word(OP_RUN, 0, 0);
      for (int i = 0; i < 7; i++) push_word(OP_ADD, 16 + 2 * i, 17 + 2 * i);
      push_word(OP_ADD, 100, 101);
      push_word(OP_ADD, 30, 102);
      push_word(OP_RUN, 0, 0);
      push_word(OP_CLEAR, 0, 0);
      push_word(OP_RUN, 0, 0);
      for (int i = 0; i < 4; i++)
         for (int j = i + 1; j < 4; j++) push_word(OP_ADD, i + 1, j + 1);
      push_word(OP_RUN, 0, 0);
      for (int i = 0; i < 130; i++) push_word(OP_ADD, 7, 7);
      push_word(OP_ADD, 7, 1);
      push_word(OP_RUN, 0, 0);
      push_word(OP_CLEAR, 0, 0);

      for (int k = 0; k < 150; k++) begin
         case ($urandom_range(0, 19))
            0: push_word(OP_CLEAR, $urandom, $urandom);
            1: push_word(OP_NONE, $urandom, $urandom);
            2, 3, 4: push_word(OP_RUN, $urandom, $urandom);
            5: push_word(OP_ADD, $urandom, $urandom);
            default: begin
               pool_size = $urandom_range(0, 1) ? 8 : 20;
               push_word(OP_ADD, $urandom_range(0, pool_size - 1) * 13,
                         $urandom_range(0, pool_size - 1) * 13);
            end
         endcase
      end
      push_word(OP_RUN, 0, 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (pending_words.size() == 0);
      stimulus_done = 1'b1;
      wait (expected_colours.size() == 0);
      repeat (200) @(posedge clock);
      if (!failed && expected_colours.size() == 0) begin
         $display("greedy_graph_colouring_core regression: pass");
      end else begin
         $display("greedy_graph_colouring_core regression: fail");
      end
      $finish;
   end

endmodule
